[design/lfpm_pkg.sv]
// Shared widths, register codes and constants of the line follower motor mixer.
package lfpm_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int RUN_COUNT_BITS = 32;

  localparam int THR_BITS   = 10;
  localparam int MAXE_BITS  = 6;
  localparam int DUTY_CFG_BITS = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int ERR_BITS   = 7;
  localparam int CMP_OUT_BITS = 16;

  // Sample and threshold compare width.
  localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  // Sum of two run counts minus one.
  localparam int N_BITS = RUN_COUNT_BITS + 1;
  // Proportional term 4 * e * pot, signed.
  localparam int P2_BITS = SAMPLE_BITS + 10;
  // |diff| * pot, then times DERIV_SCALE.
  localparam int XM_BITS   = SAMPLE_BITS + 7;
  localparam int XMAG_BITS = XM_BITS + 12;
  localparam int G_BITS    = XMAG_BITS + 2;
  localparam int DUTY_BITS = G_BITS + 4;
  localparam int STEP_BITS = $clog2(XMAG_BITS);

  localparam int IN_DATA_BITS  = ((4 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_USED_BITS = 4 * CMP_OUT_BITS + ERR_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_USED_BITS;

  // Derivative gain is twice the pot reading, and the term carries 2000.
  localparam int DERIV_SCALE = 4000;
  localparam int MAX_TURN_LEFT_X2 = 62000;
  localparam int MAX_TURN_RIGHT   = 33000;
  localparam int COMPARE_MAX = 65535;
  localparam int COMPARE_OFF = 1;

  localparam logic [THR_BITS-1:0]      RST_ON_THRESHOLD   = 10'd200;
  localparam logic [THR_BITS-1:0]      RST_FOIL_THRESHOLD = 10'd52;
  localparam logic [MAXE_BITS-1:0]     RST_MAX_ERROR      = 6'd13;
  localparam logic [DUTY_CFG_BITS-1:0] RST_NOM_LEFT       = 16'd33000;
  localparam logic [DUTY_CFG_BITS-1:0] RST_NOM_RIGHT      = 16'd35000;
  localparam logic [DUTY_CFG_BITS-1:0] RST_REV_LEFT       = 16'd31000;
  localparam logic [DUTY_CFG_BITS-1:0] RST_REV_RIGHT      = 16'd33000;
  localparam logic [DUTY_CFG_BITS-1:0] RST_REV_CORR       = 16'd1300;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ON_THRESHOLD   = 3'd0,
    REG_FOIL_THRESHOLD = 3'd1,
    REG_MAX_ERROR      = 3'd2,
    REG_NOM_LEFT       = 3'd3,
    REG_NOM_RIGHT      = 3'd4,
    REG_REV_LEFT       = 3'd5,
    REG_REV_RIGHT      = 3'd6,
    REG_REV_CORR       = 3'd7
  } cfg_reg_t;

endpackage

[design/line_follow_pd_motor_mixer_top.sv]
// Two-sensor PD line follower with asymmetric motor mixing and a serial divider.
//
//  channel  direction  signals                       word
//  s_       in         s_tvalid s_tready s_tdata     samples: left, right, p pot, d pot
//  m_       out        m_tvalid m_tready m_tdata     four compares, track error
//                      m_tuser                       foil_stop
//  cfg_     in         cfg_valid cfg_ready           cfg_index, cfg_data
//
// Once an error change has been seen, a tracking word passes the evaluate, multiply, scale,
// divide, fix and mix steps before it is loaded into the output register; before that the
// divide step is skipped, and a foil word goes from evaluation straight to the mix step.
// The restoring divider that forms the derivative term, one quotient bit per cycle, is the
// longest step. The sequencer is idle again after the mix step and takes no new word until then.
// s_tready is high only while the sequencer is idle; a finished result waits in the output
// register while the next word is processed, and the last step holds while it is full.
// Reset (rst, synchronous) restores the register defaults and clears the error history.
module line_follow_pd_motor_mixer_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // left_sample, right_sample, p_pot_sample, d_pot_sample
  input  logic [lfpm_pkg::IN_DATA_BITS-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // left_forward_compare, left_reverse_compare, right_forward_compare,
  // right_reverse_compare, track_error, zero pad
  output logic [lfpm_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // foil_stop
  output logic                                 m_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lfpm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lfpm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int SB = lfpm_pkg::SAMPLE_BITS;
  localparam int RB = lfpm_pkg::RUN_COUNT_BITS;
  localparam int NB = lfpm_pkg::N_BITS;
  localparam int EB = lfpm_pkg::ERR_BITS;
  localparam int PB = lfpm_pkg::P2_BITS;
  localparam int XB = lfpm_pkg::XM_BITS;
  localparam int QB = lfpm_pkg::XMAG_BITS;
  localparam int GB = lfpm_pkg::G_BITS;
  localparam int DB = lfpm_pkg::DUTY_BITS;
  localparam int CB = lfpm_pkg::CMP_BITS;
  localparam int OB = lfpm_pkg::CMP_OUT_BITS;

  localparam logic signed [DB-1:0] DUTY_MAX = DB'(lfpm_pkg::COMPARE_MAX);
  localparam logic signed [DB-1:0] DUTY_OFF = DB'(lfpm_pkg::COMPARE_OFF);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_MUL, S_SCALE, S_DIV, S_FIX, S_MIX
  } state_t;

  function automatic logic [OB-1:0] clamp_cmp(input logic signed [DB-1:0] v);
    logic [OB-1:0] r;
    if (v < DUTY_OFF) r = OB'(lfpm_pkg::COMPARE_OFF);
    else if (v > DUTY_MAX) r = OB'(lfpm_pkg::COMPARE_MAX);
    else r = v[OB-1:0];
    return r;
  endfunction

  state_t state;

  // Configuration registers.
  logic [lfpm_pkg::THR_BITS-1:0]      on_threshold, foil_threshold;
  logic [lfpm_pkg::MAXE_BITS-1:0]     max_error;
  logic [lfpm_pkg::DUTY_CFG_BITS-1:0] nominal_left_duty, nominal_right_duty;
  logic [lfpm_pkg::DUTY_CFG_BITS-1:0] reverse_left_duty, reverse_right_duty;
  logic [lfpm_pkg::DUTY_CFG_BITS-1:0] reverse_trim;

  // Error history.
  logic signed [EB-1:0] last_error, prior_error;
  logic                 last_error_valid, prior_run_valid;
  logic [RB-1:0]        run_count, prior_run_count;

  // Word being processed.
  logic [SB-1:0]        left_s, right_s, p_pot, d_pot;
  logic signed [EB-1:0] err;
  logic                 foil, is_max, x_neg;
  logic signed [PB-1:0] p2;
  logic [XB-1:0]        xm;
  logic [NB-1:0]        n;
  logic [QB-1:0]        div_q;
  logic [NB-1:0]        rem;
  logic [lfpm_pkg::STEP_BITS-1:0] step;
  logic signed [GB-1:0] g;

  // Evaluation of the samples.
  logic [CB-1:0]        ls_c, rs_c, on_c, foil_c;
  logic                 lon, ron, foil_hit;
  logic signed [EB-1:0] mx, e_new;

  always_comb begin
    ls_c   = CB'(left_s);
    rs_c   = CB'(right_s);
    on_c   = CB'(on_threshold);
    foil_c = CB'(foil_threshold);
    foil_hit = (ls_c < foil_c) && (rs_c < foil_c);
    lon = ls_c > on_c;
    ron = rs_c > on_c;
    mx  = $signed({1'b0, max_error});
    if (lon && ron) e_new = '0;
    else if (!lon && ron) e_new = -EB'(1);
    else if (lon && !ron) e_new = EB'(1);
    else if (last_error_valid && last_error[EB-1]) e_new = -mx;
    else e_new = mx;
  end

  // Products formed after the history update.
  logic signed [PB-1:0] e_ext, pot_ext, p_prod;
  logic signed [EB:0]   diff;
  logic [EB-1:0]        abs_diff;
  logic [XB-1:0]        xm_prod;
  logic [QB-1:0]        xmag;

  always_comb begin
    e_ext   = PB'(err);
    pot_ext = $signed({{(PB-SB){1'b0}}, p_pot});
    p_prod  = e_ext * pot_ext;
    diff    = {err[EB-1], err} - {prior_error[EB-1], prior_error};
    abs_diff = diff[EB] ? EB'(-diff) : diff[EB-1:0];
    xm_prod = {{(XB-EB){1'b0}}, abs_diff} * {{(XB-SB){1'b0}}, d_pot};
    xmag    = {{(QB-XB){1'b0}}, xm} * QB'(lfpm_pkg::DERIV_SCALE);
  end

  // One restoring division step: remainder shifted in from the dividend top.
  logic [NB:0]   rem_sh, rem_sub;
  logic          rem_ge;
  logic [NB-1:0] rem_next;

  always_comb begin
    rem_sh  = {rem, div_q[QB-1]};
    rem_sub = rem_sh - {1'b0, n};
    rem_ge  = rem_sh >= {1'b0, n};
    rem_next = rem_ge ? rem_sub[NB-1:0] : rem_sh[NB-1:0];
  end

  // (p2*n + x) / n truncated equals p2 + trunc(x/n), moved by one toward zero
  // when the remainder and the sum disagree in sign.
  logic signed [GB-1:0] q_mag, q_sgn, g_sum, g_next;

  always_comb begin
    q_mag = $signed({{(GB-QB){1'b0}}, div_q});
    q_sgn = x_neg ? -q_mag : q_mag;
    g_sum = q_sgn + GB'(p2);
    g_next = g_sum;
    if (rem != '0) begin
      if (x_neg && !g_sum[GB-1] && (g_sum != '0)) g_next = g_sum - GB'(1);
      else if (!x_neg && g_sum[GB-1]) g_next = g_sum + GB'(1);
    end
  end

  // Wheel mixing and drive.
  logic signed [DB-1:0] gd, g3, neg_g, arc, nom_l, nom_r, ld, rd;
  logic signed [DB-1:0] ld_neg, rd_neg;
  logic                 g_pos, g_neg;
  logic [OB-1:0]        lf, lr, rf, rr;

  always_comb begin
    gd    = DB'(g);
    g3    = gd + (gd <<< 1);
    neg_g = -gd;
    g_neg = g[GB-1];
    g_pos = !g[GB-1] && (g != '0);
    nom_l = $signed({{(DB-16){1'b0}}, nominal_left_duty});
    nom_r = $signed({{(DB-16){1'b0}}, nominal_right_duty});
    arc   = DB'(lfpm_pkg::MAX_TURN_LEFT_X2) - g3;
    ld = nom_l;
    rd = nom_r;
    if (foil) begin
      ld = -($signed({{(DB-16){1'b0}}, reverse_left_duty})
             + $signed({{(DB-16){1'b0}}, reverse_trim}));
      rd = -$signed({{(DB-16){1'b0}}, reverse_right_duty});
    end else if (is_max) begin
      if (g_pos) begin
        rd = nom_r + gd;
        // Halving truncates toward zero.
        ld = (arc >>> 1) + $signed(DB'(arc[DB-1] & arc[0]));
      end else if (g_neg) begin
        ld = nom_l - gd;
        rd = DB'(lfpm_pkg::MAX_TURN_RIGHT) - ((neg_g + (neg_g <<< 1)) >>> 2);
      end
    end else begin
      if (g_pos) begin
        rd = nom_r + gd;
        ld = nom_l - (gd >>> 1);
      end else if (g_neg) begin
        ld = nom_l - gd;
        rd = nom_r - (neg_g >>> 1);
      end
    end
    ld_neg = -ld;
    rd_neg = -rd;
    if (ld > DB'(0)) begin
      lf = clamp_cmp(ld);
      lr = OB'(lfpm_pkg::COMPARE_OFF);
    end else begin
      lf = OB'(lfpm_pkg::COMPARE_OFF);
      lr = clamp_cmp(ld_neg);
    end
    if (rd > DB'(0)) begin
      rf = clamp_cmp(rd);
      rr = OB'(lfpm_pkg::COMPARE_OFF);
    end else begin
      rf = OB'(lfpm_pkg::COMPARE_OFF);
      rr = clamp_cmp(rd_neg);
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      m_tvalid           <= 1'b0;
      on_threshold       <= lfpm_pkg::RST_ON_THRESHOLD;
      foil_threshold     <= lfpm_pkg::RST_FOIL_THRESHOLD;
      max_error          <= lfpm_pkg::RST_MAX_ERROR;
      nominal_left_duty  <= lfpm_pkg::RST_NOM_LEFT;
      nominal_right_duty <= lfpm_pkg::RST_NOM_RIGHT;
      reverse_left_duty  <= lfpm_pkg::RST_REV_LEFT;
      reverse_right_duty <= lfpm_pkg::RST_REV_RIGHT;
      reverse_trim       <= lfpm_pkg::RST_REV_CORR;
      last_error         <= '0;
      last_error_valid   <= 1'b0;
      run_count          <= RB'(1);
      prior_run_count    <= '0;
      prior_run_valid    <= 1'b0;
      prior_error        <= '0;
    end else begin
      if (cfg_valid) begin
        case (lfpm_pkg::cfg_reg_t'(cfg_index))
          lfpm_pkg::REG_ON_THRESHOLD:   on_threshold <= cfg_data[lfpm_pkg::THR_BITS-1:0];
          lfpm_pkg::REG_FOIL_THRESHOLD: foil_threshold <= cfg_data[lfpm_pkg::THR_BITS-1:0];
          lfpm_pkg::REG_MAX_ERROR:      max_error <= cfg_data[lfpm_pkg::MAXE_BITS-1:0];
          lfpm_pkg::REG_NOM_LEFT:       nominal_left_duty <= cfg_data;
          lfpm_pkg::REG_NOM_RIGHT:      nominal_right_duty <= cfg_data;
          lfpm_pkg::REG_REV_LEFT:       reverse_left_duty <= cfg_data;
          lfpm_pkg::REG_REV_RIGHT:      reverse_right_duty <= cfg_data;
          lfpm_pkg::REG_REV_CORR:       reverse_trim <= cfg_data;
          default: ;
        endcase
      end

      // The output register loads from the last step, else it empties on a handshake.
      if (state == S_MIX && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            left_s  <= s_tdata[SB-1:0];
            right_s <= s_tdata[2*SB-1:SB];
            p_pot   <= s_tdata[3*SB-1:2*SB];
            d_pot   <= s_tdata[4*SB-1:3*SB];
            state   <= S_EVAL;
          end
        end
        S_EVAL: begin
          foil   <= foil_hit;
          err    <= foil_hit ? '0 : e_new;
          is_max <= (e_new == mx) || (e_new == -mx);
          g      <= '0;
          if (foil_hit) begin
            state <= S_MIX;
          end else begin
            if (last_error_valid) begin
              if (last_error == e_new) begin
                if (run_count != '1) run_count <= run_count + RB'(1);
              end else begin
                prior_run_count <= run_count;
                prior_error     <= last_error;
                run_count       <= RB'(1);
                prior_run_valid <= 1'b1;
              end
            end
            last_error       <= e_new;
            last_error_valid <= 1'b1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p2    <= p_prod <<< 2;
          xm    <= xm_prod;
          x_neg <= diff[EB];
          n     <= {1'b0, prior_run_count} + {1'b0, run_count} - NB'(1);
          state <= S_SCALE;
        end
        S_SCALE: begin
          rem  <= '0;
          step <= '0;
          if (prior_run_valid) begin
            div_q <= xmag;
            state <= S_DIV;
          end else begin
            div_q <= '0;
            state <= S_FIX;
          end
        end
        S_DIV: begin
          rem   <= rem_next;
          div_q <= {div_q[QB-2:0], rem_ge};
          step  <= step + lfpm_pkg::STEP_BITS'(1);
          if (step == lfpm_pkg::STEP_BITS'(QB - 1)) state <= S_FIX;
        end
        S_FIX: begin
          g     <= g_next;
          state <= S_MIX;
        end
        S_MIX: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {{lfpm_pkg::OUT_PAD_BITS{1'b0}}, err, rr, rf, lr, lf};
            m_tuser  <= foil;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A word is taken only once: the sequencer leaves idle right after.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // A foil result carries no tracking error.
  a_foil_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[4*OB+EB-1:4*OB] == '0)
    else $error("foil result with nonzero track error");

  // A wheel is driven in one direction at most.
  a_one_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OB-1:0] == OB'(1) || m_tdata[2*OB-1:OB] == OB'(1))
              && (m_tdata[3*OB-1:2*OB] == OB'(1) || m_tdata[4*OB-1:3*OB] == OB'(1)))
    else $error("wheel driven both ways");

  // Compare values never reach zero.
  a_cmp_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OB-1:0] != '0 && m_tdata[2*OB-1:OB] != '0
              && m_tdata[3*OB-1:2*OB] != '0 && m_tdata[4*OB-1:3*OB] != '0)
    else $error("compare value of zero");

  // The run count starts at one and saturates, so it is never zero.
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    run_count != '0)
    else $error("run count reached zero");

  // The divider only runs with a nonzero divisor.
  a_div_n: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> n != '0)
    else $error("division by zero run length");

endmodule
